### rtl/hfs_pkg.sv
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types, constants and the FNV-1a step for the hashed failure set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hfs_pkg;

  // number of stored hashes, one per cell
  localparam int SetDepth = 16;
  // entry count holds 0 .. SetDepth
  localparam int CntW = $clog2(SetDepth + 1);

  // 64-bit FNV-1a offset basis
  localparam logic [63:0] HashBasis = 64'd14695981039346656037;

  // mode codes
  localparam logic [1:0] ModeLookup   = 2'd0;
  localparam logic [1:0] ModeRemember = 2'd1;
  localparam logic [1:0] ModeClear    = 2'd2;

  // input word
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] name_byte;
    logic       last_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        found;
    logic        inserted;
    logic        set_full;
    logic [63:0] name_hash;
  } out_word_t;

  // probe handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        remember;
    logic        found;
    logic        inserted;
    logic        set_full;
    logic [63:0] hash;
  } probe_t;

  // multiply by the FNV prime 2^40 + 2^8 + 0xb3, as shifts and adds mod 2^64
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

### rtl/hashed_failure_set_core.sv
// ----------------------------------------------------------------------------
// hashed_failure_set_core
// FNV-1a 64-bit name hashing with a bounded set of stored hashes.
// ----------------------------------------------------------------------------
// middle bytes and clears: one word per cycle while no probe is in flight
// last byte: the result passes the launch register, each cell of the entry
//   chain and the output register; input stalls until the probe has left the
//   chain, so only one name end is in the chain at a time
// reset: hash at the offset basis, set empty, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module hashed_failure_set_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hfs_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hfs_pkg::out_word_t      out_word_o
);

  localparam int Depth = hfs_pkg::SetDepth;

  logic                     in_acc;
  logic                     is_name;
  logic                     is_clear;
  logic                     advance;
  logic                     busy;
  logic [63:0]              hash;
  logic [hfs_pkg::CntW-1:0] count_q, count_d;
  hfs_pkg::probe_t          launch_q;
  hfs_pkg::probe_t          chain [Depth+1];
  hfs_pkg::probe_t          tail;
  logic                     out_valid_q;
  hfs_pkg::out_word_t       out_q;

  // input decode
  assign in_acc   = in_valid_i && in_ready_o;
  assign is_name  = in_acc && ((in_word_i.mode == hfs_pkg::ModeLookup) ||
                               (in_word_i.mode == hfs_pkg::ModeRemember));
  assign is_clear = in_acc && (in_word_i.mode == hfs_pkg::ModeClear);

  hfs_hash u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (is_name),
    .restart_i (is_clear || (is_name && in_word_i.last_byte)),
    .byte_i    (in_word_i.name_byte),
    .hash_o    (hash)
  );

  // chain stalls only when a result is blocked at the exit
  assign tail    = chain[Depth];
  assign advance = !(tail.valid && out_valid_q && !out_ready_i);

  // any probe in flight
  always_comb begin
    busy = launch_q.valid;
    for (int i = 1; i <= Depth; i++) begin
      busy = busy | chain[i].valid;
    end
  end

  assign in_ready_o = !busy;

  // launch register in front of the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else if (advance) begin
      launch_q.valid    <= is_name && in_word_i.last_byte;
      launch_q.remember <= (in_word_i.mode == hfs_pkg::ModeRemember);
      launch_q.found    <= 1'b0;
      launch_q.inserted <= 1'b0;
      launch_q.set_full <= (count_q == hfs_pkg::CntW'(Depth));
      launch_q.hash     <= hash;
    end
  end

  assign chain[0] = launch_q;

  // row of entry cells
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    hfs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .idx_i     (hfs_pkg::CntW'(g)),
      .count_i   (count_q),
      .probe_i   (chain[g]),
      .probe_o   (chain[g+1])
    );
  end

  // entry count, bumped once the probe leaves the chain
  always_comb begin
    count_d = count_q;
    if (is_clear) begin
      count_d = '0;
    end else if (tail.valid && advance && tail.inserted) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tail.valid && advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid && advance) begin
      out_q.found     <= tail.found;
      out_q.inserted  <= tail.inserted;
      out_q.set_full  <= tail.set_full;
      out_q.name_hash <= tail.hash;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### rtl/hfs_hash.sv
// ----------------------------------------------------------------------------
// hfs_hash
// Running FNV-1a hash register, folds one name byte per cycle in which step_i is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfs_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        restart_i,
  input  wire logic [7:0]  byte_i,
  output logic      [63:0] hash_o
);

  logic [63:0] run_q, run_d;

  // xor the byte, then multiply by the prime
  assign hash_o = hfs_pkg::fnv_mul(run_q ^ {56'd0, byte_i});

  // back to the basis at end of name or clear
  always_comb begin
    run_d = run_q;
    if (restart_i) begin
      run_d = hfs_pkg::HashBasis;
    end else if (step_i) begin
      run_d = hash_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= hfs_pkg::HashBasis;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

`default_nettype wire

### rtl/hfs_cell.sv
// ----------------------------------------------------------------------------
// hfs_cell
// One set entry: compares the passing probe and takes the hash at the tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfs_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     advance_i,
  input  wire logic [hfs_pkg::CntW-1:0] idx_i,
  input  wire logic [hfs_pkg::CntW-1:0] count_i,
  input  wire hfs_pkg::probe_t          probe_i,
  output hfs_pkg::probe_t               probe_o
);

  logic [63:0]     entry_q;
  hfs_pkg::probe_t probe_q, probe_d;
  logic            hit;
  logic            tail_wr;

  // a live entry matching the probe
  assign hit = probe_i.valid && (idx_i < count_i) && (entry_q == probe_i.hash);

  // first free entry takes a remembered hash not seen in earlier cells
  assign tail_wr = probe_i.valid && probe_i.remember && !probe_i.found &&
                   (idx_i == count_i);

  always_comb begin
    probe_d          = probe_i;
    probe_d.found    = probe_i.found | hit;
    probe_d.inserted = probe_i.inserted | tail_wr;
  end

  // probe register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else if (advance_i) begin
      probe_q <= probe_d;
    end
  end

  // stored hash, undefined until written
  always_ff @(posedge clk_i) begin
    if (advance_i && tail_wr) begin
      entry_q <= probe_i.hash;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire
